@@ rtl/assert_macros.svh @@
// Assertion macros shared by the binned statistics RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define BMVS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define BMVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `BMVS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle.
`define BMVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `BMVS_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/bmvs_pkg.sv @@
// Package for the binned mean/variance statistics block.
// Holds widths, bin thresholds, the queue entry type, the back-end states and the bin classifier.
package bmvs_pkg;

  localparam int NBINS      = 5;
  localparam int BIN_W      = 3;
  localparam int SAMPLE_W   = 8;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 24;
  localparam int SQ_W       = 32;
  localparam int MEAN_W     = 8;
  localparam int VAR_W      = 16;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam int MAX_COUNT_DEF = 65535;

  localparam logic [SAMPLE_W-1:0] BIN1_LO = 8'd50;
  localparam logic [SAMPLE_W-1:0] BIN2_LO = 8'd100;
  localparam logic [SAMPLE_W-1:0] BIN3_LO = 8'd150;
  localparam logic [SAMPLE_W-1:0] BIN4_LO = 8'd200;

  localparam logic [BIN_W-1:0] FIRST_BIN = 3'd0;
  localparam logic [BIN_W-1:0] LAST_BIN  = 3'(NBINS - 1);

  typedef struct packed {
    logic                is_end;
    logic [BIN_W-1:0]    bin;
    logic [SAMPLE_W-1:0] sample;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_START,
    ST_DIV,
    ST_SQR,
    ST_OUT
  } back_state_t;

  function automatic logic [BIN_W-1:0] pick_bin(input logic [SAMPLE_W-1:0] s);
    logic [BIN_W-1:0] b;
    if (s < BIN1_LO)      b = 3'd0;
    else if (s < BIN2_LO) b = 3'd1;
    else if (s < BIN3_LO) b = 3'd2;
    else if (s < BIN4_LO) b = 3'd3;
    else                  b = 3'd4;
    return b;
  endfunction

endpackage

@@ rtl/bmvs_front.sv @@
// Front end: accepts samples, classifies them into bins or end markers.
// Depends on bmvs_pkg; feeds bmvs_queue.
module bmvs_front import bmvs_pkg::*; (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                q_full,
  output logic                q_push,
  output q_entry_t            q_wdata
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.is_end = (in_sample == '0);
    q_wdata.bin    = pick_bin(in_sample);
    q_wdata.sample = in_sample;
  end

endmodule

@@ rtl/bmvs_queue.sv @@
// Short request queue between the front end and the back end.
// Depends on bmvs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bmvs_queue import bmvs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     rvalid,
  output q_entry_t rdata
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  `BMVS_ASSERT(a_q_cnt_range, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH), "queue count out of range")
  `BMVS_ASSERT_IMPL(a_q_ptr_gap, clk, rst_n, (cnt_r != QCNT_W'(QDEPTH)), (wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0], "queue pointers disagree with count")
  `BMVS_ASSERT_NEXT(a_q_fill, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "queue count did not advance on push")

endmodule

@@ rtl/bmvs_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bmvs_pkg; used twice by bmvs_back.
module bmvs_div import bmvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [COUNT_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]   dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [COUNT_W:0]     trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt = ge ? COUNT_W'(trial - {1'b0, dvs_r}) : trial[COUNT_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/bmvs_back.sv @@
// Back end: per-bin accumulators and the report sequencer with two dividers.
// Depends on bmvs_pkg, bmvs_div and assert_macros.svh.
`include "assert_macros.svh"
module bmvs_back import bmvs_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  q_entry_t           q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BIN_W-1:0]   out_bin_index,
  output logic [COUNT_W-1:0] out_sample_count,
  output logic [MEAN_W-1:0]  out_mean_value,
  output logic [VAR_W-1:0]   out_variance_value,
  output logic               out_bin_saturated,
  output logic               out_last_of_report
);

  back_state_t        state_r, state_nxt;
  logic [COUNT_W-1:0] cnt_r  [NBINS];
  logic [SUM_W-1:0]   sum_r  [NBINS];
  logic [SQ_W-1:0]    sq_r   [NBINS];
  logic               flag_r [NBINS];
  logic [BIN_W-1:0]   rpt_bin_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [VAR_W-1:0]   qsq_r;

  logic               acc_en, div_start, out_load, out_take, clr_all;
  logic               sum_done, sq_done;
  logic [DIV_W-1:0]   sum_quo, sq_quo;
  logic [VAR_W-1:0]   msq;
  logic [VAR_W-1:0]   var_val;
  logic               bin_empty;
  logic [VAR_W-1:0]   samp_sq;

  bmvs_div u_div_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{(DIV_W-SUM_W){1'b0}}, sum_r[rpt_bin_r]}),
    .divisor  (cnt_r[rpt_bin_r]),
    .done     (sum_done),
    .quotient (sum_quo)
  );

  bmvs_div u_div_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sq_r[rpt_bin_r]),
    .divisor  (cnt_r[rpt_bin_r]),
    .done     (sq_done),
    .quotient (sq_quo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:   if (q_valid && q_rdata.is_end) state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (sum_done && sq_done) state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = (rpt_bin_r == LAST_BIN) ? ST_RUN : ST_START;
      end
      default:  state_nxt = ST_RUN;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    acc_en    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    out_take  = 1'b0;
    case (state_r)
      ST_RUN: begin
        q_pop  = q_valid;
        acc_en = q_valid && !q_rdata.is_end;
      end
      ST_START: div_start = 1'b1;
      ST_SQR:   out_load  = 1'b1;
      ST_OUT:   out_take  = !out_stall;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign clr_all   = out_take && (rpt_bin_r == LAST_BIN);
  assign out_valid = (state_r == ST_OUT);
  assign samp_sq   = VAR_W'(q_rdata.sample * q_rdata.sample);
  assign msq       = VAR_W'(mean_r * mean_r);
  assign bin_empty = (cnt_r[rpt_bin_r] == '0);
  assign var_val   = (qsq_r >= msq) ? (qsq_r - msq) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      rpt_bin_r <= FIRST_BIN;
      for (int i = 0; i < NBINS; i++) begin
        cnt_r[i]  <= '0;
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
        flag_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (acc_en) begin
        if (cnt_r[q_rdata.bin] >= COUNT_W'(MAX_COUNT)) begin
          flag_r[q_rdata.bin] <= 1'b1;
        end else begin
          cnt_r[q_rdata.bin] <= cnt_r[q_rdata.bin] + 1'b1;
          sum_r[q_rdata.bin] <= sum_r[q_rdata.bin] + SUM_W'(q_rdata.sample);
          sq_r[q_rdata.bin]  <= sq_r[q_rdata.bin] + SQ_W'(samp_sq);
        end
      end
      if (state_r == ST_RUN && q_valid && q_rdata.is_end) rpt_bin_r <= FIRST_BIN;
      else if (out_take && !clr_all) rpt_bin_r <= rpt_bin_r + 1'b1;
      if (clr_all) begin
        for (int i = 0; i < NBINS; i++) begin
          cnt_r[i]  <= '0;
          sum_r[i]  <= '0;
          sq_r[i]   <= '0;
          flag_r[i] <= 1'b0;
        end
      end
    end
  end

  // Quotients and result payload.
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && sum_done) begin
      mean_r <= sum_quo[MEAN_W-1:0];
      qsq_r  <= sq_quo[VAR_W-1:0];
    end
    if (out_load) begin
      out_bin_index      <= rpt_bin_r;
      out_sample_count   <= cnt_r[rpt_bin_r];
      out_mean_value     <= bin_empty ? '0 : mean_r;
      out_variance_value <= bin_empty ? '0 : var_val;
      out_bin_saturated  <= flag_r[rpt_bin_r];
      out_last_of_report <= (rpt_bin_r == LAST_BIN);
    end
  end

  `BMVS_ASSERT_IMPL(a_last_flag, clk, rst_n, out_valid, out_last_of_report == (out_bin_index == LAST_BIN), "last flag disagrees with bin index")
  `BMVS_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && (out_sample_count == '0), (out_mean_value == '0) && (out_variance_value == '0), "empty bin reports nonzero statistics")
  `BMVS_ASSERT_NEXT(a_clear, clk, rst_n, clr_all, (cnt_r[0] == '0) && (cnt_r[4] == '0) && !flag_r[0] && !flag_r[4], "accumulators not cleared after report")

endmodule

@@ rtl/binned_mean_variance_stats.sv @@
// Binned mean/variance statistics: accepts one sample per cycle while the queue is not full.
// A zero sample starts a report: each bin passes through start, divide, load and output,
// the output step holding while out_stall is high, until all five bins have been taken.
// Samples queued behind the end marker wait in the 4-entry queue until the report ends.
// Synchronous active-low reset clears the queue, sequencer, counts, sums and flags.
// Depends on bmvs_pkg, bmvs_front, bmvs_queue, bmvs_div and bmvs_back.
module binned_mean_variance_stats import bmvs_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BIN_W-1:0]   out_bin_index,
  output logic [COUNT_W-1:0] out_sample_count,
  output logic [MEAN_W-1:0]  out_mean_value,
  output logic [VAR_W-1:0]   out_variance_value,
  output logic               out_bin_saturated,
  output logic               out_last_of_report
);

  // Request path: front end classifies, queue decouples, back end executes.
  q_entry_t q_wdata, q_rdata;
  logic     q_push, q_full, q_pop, q_valid;

  // Classify each sample as a bin update or an end-of-run marker.
  bmvs_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Hold requests while the back end is busy reporting.
  bmvs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // Accumulate samples; on an end marker, divide out and emit the five bins.
  bmvs_back #(
    .MAX_COUNT (MAX_COUNT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_index      (out_bin_index),
    .out_sample_count   (out_sample_count),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_bin_saturated  (out_bin_saturated),
    .out_last_of_report (out_last_of_report)
  );

endmodule
